>>> hdl/fspd_pkg.sv
// Package for the fan speed block: state encoding, register indexes,
// arithmetic constants and widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fspd_pkg;

  localparam int TEMP_W = 19;
  localparam int OFF_W  = 18;
  localparam int PCT_W  = 7;
  localparam int SPD_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int DIV_W  = 28;
  localparam int CNT_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL    = 2'd2;

  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
  localparam logic signed [20:0] FLOOR_BACKOFF = 21'sd3000;

  // starting step counts: 7 steps for the percent, 16 for the speed
  localparam logic [CNT_W-1:0] PCT_CNT_INIT = 4'd6;
  localparam logic [CNT_W-1:0] SPD_CNT_INIT = 4'd15;
  localparam logic [DIV_W-1:0] SPD_DVS_INIT = DIV_W'(100) << 15;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FLOOR,
    S_PSETUP,
    S_PDIV,
    S_MAX,
    S_SSETUP,
    S_SDIV,
    S_SFIN,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

>>> hdl/fspd_in_if.sv
// Request channel into the fan speed block: one sensor reading of a pass.
// Depends on fspd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface fspd_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [fspd_pkg::TEMP_W-1:0]       sensor_temp;
  logic signed [fspd_pkg::TEMP_W-1:0]       sensor_min;
  logic signed [fspd_pkg::TEMP_W-1:0]       sensor_max;
  logic signed [fspd_pkg::OFF_W-1:0]        sensor_offset;
  logic signed [fspd_pkg::TEMP_W-1:0]       ambient_temp;
  logic                                     last_sensor;

  modport source (
    output valid, sensor_temp, sensor_min, sensor_max, sensor_offset,
           ambient_temp, last_sensor,
    input  ready
  );
  modport sink (
    input  valid, sensor_temp, sensor_min, sensor_max, sensor_offset,
           ambient_temp, last_sensor,
    output ready
  );
endinterface
`default_nettype wire

>>> hdl/fspd_out_if.sv
// Result channel out of the fan speed block: percent and fan speed.
// Depends on fspd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface fspd_out_if;
  logic                          valid;
  logic                          ready;
  logic [fspd_pkg::PCT_W-1:0]    sensor_percent;
  logic                          speed_valid;
  logic [fspd_pkg::SPD_W-1:0]    fan_speed;
  logic                          speed_write;

  modport source (
    output valid, sensor_percent, speed_valid, fan_speed, speed_write,
    input  ready
  );
  modport sink (
    input  valid, sensor_percent, speed_valid, fan_speed, speed_write,
    output ready
  );
endinterface
`default_nettype wire

>>> hdl/fan_speed_from_sensor_max_unit.sv
// Top level of the fan speed block: sequencer around one shared
// compare-subtract divider. Depends on fspd_pkg, fspd_in_if, fspd_out_if.
//
// Channel   Dir  Handshake           Payload
// in_chan   in   valid/ready         sensor reading, limits, ambient, last flag
// out_chan  out  valid/ready         percent, speed_valid, fan_speed, speed_write
// cfg_*     in   cfg_we only         cfg_index, cfg_data
//
// A request goes through S_PDIV when the percent needs the divider and skips it
// when the percent is 0 or 100 outright; the last sensor of a pass adds the speed
// division. The shared divider runs 7 steps for the percent, 16 for the speed;
// in_chan.ready returns in the cycle after the result loads. The result register
// holds while out_chan stalls, and a second result waits in S_FINISH. rst_n is
// synchronous and clears state, running max, stored speed and config registers.
`timescale 1ns / 1ps
`default_nettype none
module fan_speed_from_sensor_max_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [fspd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [fspd_pkg::CFG_DAT_W-1:0]    cfg_data,
  fspd_in_if.sink                          in_chan,
  fspd_out_if.source                       out_chan
);

  fspd_pkg::state_t state_r, state_nxt;

  logic signed [fspd_pkg::TEMP_W-1:0] t_r, lo_r, hi_r, amb_r;
  logic signed [fspd_pkg::OFF_W-1:0]  off_r;
  logic                               last_r;

  logic signed [20:0]                 floor_r, floor_nxt;
  logic [fspd_pkg::DIV_W-1:0]         rem_r, rem_nxt;
  logic [fspd_pkg::DIV_W-1:0]         dvs_r, dvs_nxt;
  logic [fspd_pkg::SPD_W-1:0]         q_r, q_nxt;
  logic [fspd_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [fspd_pkg::PCT_W-1:0]         pct_r, pct_nxt;
  logic [fspd_pkg::PCT_W-1:0]         maxpct_r, maxpct_nxt;
  logic                               neg_r, neg_nxt;
  logic [fspd_pkg::SPD_W-1:0]         speed_r, speed_nxt;
  logic                               wr_r, wr_nxt;
  logic [fspd_pkg::SPD_W-1:0]         stored_r, stored_nxt;

  logic [fspd_pkg::SPD_W-1:0]         smin_r, smax_r;
  logic                               manual_r;

  logic                               out_valid_r, out_valid_nxt;
  logic [fspd_pkg::PCT_W-1:0]         out_pct_r;
  logic                               out_sv_r;
  logic [fspd_pkg::SPD_W-1:0]         out_speed_r;
  logic                               out_wr_r;

  logic in_acc, out_free, div_ge, div_last, t_ge_hi, t_le_floor;
  logic [fspd_pkg::DIV_W:0]           div_diff;
  logic signed [19:0]                 sum20, lo20, hi20;
  logic signed [21:0]                 num22, den22;
  logic signed [16:0]                 sdiff;
  logic signed [24:0]                 prod;
  logic [24:0]                        mag;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == fspd_pkg::S_IDLE);

  // shared compare-subtract unit
  assign div_diff = {1'b0, rem_r} - {1'b0, dvs_r};
  assign div_ge   = !div_diff[fspd_pkg::DIV_W];
  assign div_last = (cnt_r == '0);

  assign sum20 = 20'(amb_r) + 20'(off_r);
  assign lo20  = 20'(lo_r);
  assign hi20  = 20'(hi_r);
  assign num22 = 22'(t_r) - 22'(floor_r);
  assign den22 = 22'(hi_r) - 22'(floor_r);
  assign t_ge_hi    = (t_r >= hi_r);
  assign t_le_floor = (21'(t_r) <= floor_r);
  assign sdiff = $signed({1'b0, smax_r}) - $signed({1'b0, smin_r});
  assign prod  = 25'(sdiff) * 25'($signed({1'b0, maxpct_r}));
  assign mag   = prod[24] ? 25'(-prod) : 25'(prod);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fspd_pkg::S_IDLE:   if (in_acc) state_nxt = fspd_pkg::S_FLOOR;
      fspd_pkg::S_FLOOR:  state_nxt = fspd_pkg::S_PSETUP;
      fspd_pkg::S_PSETUP: begin
        if (t_ge_hi || t_le_floor) state_nxt = fspd_pkg::S_MAX;
        else state_nxt = fspd_pkg::S_PDIV;
      end
      fspd_pkg::S_PDIV:   if (div_last) state_nxt = fspd_pkg::S_MAX;
      fspd_pkg::S_MAX: begin
        if (last_r) state_nxt = fspd_pkg::S_SSETUP;
        else state_nxt = fspd_pkg::S_FINISH;
      end
      fspd_pkg::S_SSETUP: state_nxt = fspd_pkg::S_SDIV;
      fspd_pkg::S_SDIV:   if (div_last) state_nxt = fspd_pkg::S_SFIN;
      fspd_pkg::S_SFIN:   state_nxt = fspd_pkg::S_FINISH;
      fspd_pkg::S_FINISH: if (out_free) state_nxt = fspd_pkg::S_IDLE;
      default:            state_nxt = fspd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    floor_nxt     = floor_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    pct_nxt       = pct_r;
    maxpct_nxt    = maxpct_r;
    neg_nxt       = neg_r;
    speed_nxt     = speed_r;
    wr_nxt        = wr_r;
    stored_nxt    = stored_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    case (state_r)
      fspd_pkg::S_FLOOR: begin
        if (sum20 < lo20) floor_nxt = 21'(lo20);
        else floor_nxt = 21'(sum20);
        if (((sum20 < lo20) ? lo20 : sum20) >= hi20)
          floor_nxt = 21'(hi_r) - fspd_pkg::FLOOR_BACKOFF;
      end
      fspd_pkg::S_PSETUP: begin
        if (t_ge_hi) pct_nxt = fspd_pkg::PCT_FULL;
        else pct_nxt = '0;
        rem_nxt = fspd_pkg::DIV_W'(num22[19:0] * fspd_pkg::PCT_SCALE);
        dvs_nxt = fspd_pkg::DIV_W'({den22[19:0], 6'b0});
        q_nxt   = '0;
        cnt_nxt = fspd_pkg::PCT_CNT_INIT;
      end
      fspd_pkg::S_PDIV, fspd_pkg::S_SDIV: begin
        if (div_ge) rem_nxt = div_diff[fspd_pkg::DIV_W-1:0];
        q_nxt   = {q_r[fspd_pkg::SPD_W-2:0], div_ge};
        dvs_nxt = dvs_r >> 1;
        cnt_nxt = cnt_r - 4'd1;
        if (state_r == fspd_pkg::S_PDIV && div_last)
          pct_nxt = {q_r[fspd_pkg::PCT_W-2:0], div_ge};
      end
      fspd_pkg::S_MAX: begin
        if (pct_r > maxpct_r) maxpct_nxt = pct_r;
        speed_nxt = '0;
        wr_nxt    = 1'b0;
      end
      fspd_pkg::S_SSETUP: begin
        neg_nxt = prod[24];
        rem_nxt = fspd_pkg::DIV_W'(mag[22:0]);
        dvs_nxt = fspd_pkg::SPD_DVS_INIT;
        q_nxt   = '0;
        cnt_nxt = fspd_pkg::SPD_CNT_INIT;
      end
      fspd_pkg::S_SFIN: begin
        speed_nxt  = neg_r ? (smin_r - q_r) : (smin_r + q_r);
        maxpct_nxt = '0;
        if (manual_r && (speed_nxt != stored_r)) begin
          wr_nxt     = 1'b1;
          stored_nxt = speed_nxt;
        end
      end
      fspd_pkg::S_FINISH: begin
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fspd_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      maxpct_r    <= '0;
      stored_r    <= '0;
      smin_r      <= '0;
      smax_r      <= '0;
      manual_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      maxpct_r    <= maxpct_nxt;
      stored_r    <= stored_nxt;
      if (cfg_we) begin
        case (cfg_index)
          fspd_pkg::CFG_MIN_SPEED: smin_r   <= cfg_data;
          fspd_pkg::CFG_MAX_SPEED: smax_r   <= cfg_data;
          fspd_pkg::CFG_MANUAL:    manual_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      t_r    <= in_chan.sensor_temp;
      lo_r   <= in_chan.sensor_min;
      hi_r   <= in_chan.sensor_max;
      off_r  <= in_chan.sensor_offset;
      amb_r  <= in_chan.ambient_temp;
      last_r <= in_chan.last_sensor;
    end
    floor_r <= floor_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    q_r     <= q_nxt;
    cnt_r   <= cnt_nxt;
    pct_r   <= pct_nxt;
    neg_r   <= neg_nxt;
    speed_r <= speed_nxt;
    wr_r    <= wr_nxt;
    if (state_r == fspd_pkg::S_FINISH && out_free) begin
      out_pct_r   <= pct_r;
      out_sv_r    <= last_r;
      out_speed_r <= speed_r;
      out_wr_r    <= wr_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.sensor_percent = out_pct_r;
  assign out_chan.speed_valid    = out_sv_r;
  assign out_chan.fan_speed      = out_speed_r;
  assign out_chan.speed_write    = out_wr_r;

`ifndef SYNTHESIS
  a_write_needs_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_wr_r |-> out_sv_r)
    else $error("speed_write without speed_valid");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pct_r <= fspd_pkg::PCT_FULL)
    else $error("sensor_percent above full scale");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_chan.ready)
    else $error("request taken while previous one in flight");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fspd_pkg::S_PDIV |-> cnt_r <= fspd_pkg::PCT_CNT_INIT)
    else $error("percent division ran past its step count");
`endif

endmodule
`default_nettype wire
